// ----- design/ptd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants for the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int KIND_W   = 3;
  localparam int TASK_W   = 3;
  localparam int PERIOD_W = 32;
  localparam int SCAN_MAX = 8;   // a 3-bit task index names slots 0..7 only

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_CREATE  = 3'd1,
    KIND_RESUME  = 3'd2,
    KIND_SUSPEND = 3'd3,
    KIND_DELETE  = 3'd4
  } ptd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIVIDE,
    ST_ADVANCE
  } ptd_state_t;

  // Table update request, one transfer per cycle at most
  typedef struct packed {
    logic              create;
    logic              resume;
    logic              suspend;
    logic              remove;
    logic [TASK_W-1:0] idx;
  } ptd_tbl_cmd_t;

  // Remainder unit status
  typedef struct packed {
    logic done;
    logic zero;
  } ptd_rem_stat_t;

endpackage

// ----- design/ptd_rem_unit.sv -----
// ----------------------------------------------------------------------------
// ptd_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle over all 32 dividend bits.
// ----------------------------------------------------------------------------
module ptd_rem_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ptd_pkg::PERIOD_W-1:0] dividend,
  input  logic [ptd_pkg::PERIOD_W-1:0] divisor,
  output ptd_pkg::ptd_rem_stat_t       stat
);
  import ptd_pkg::*;

  localparam int CNT_W = $clog2(PERIOD_W);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PERIOD_W-1:0]   rem_r, rem_nxt;
  logic [PERIOD_W-1:0]   dvd_r, dvd_nxt;
  logic [PERIOD_W-1:0]   dsr_r, dsr_nxt;
  logic [PERIOD_W:0]     shifted;
  logic [PERIOD_W+1:0]   diff;

  assign shifted = {rem_r, dvd_r[PERIOD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      dvd_nxt = dividend;
      dsr_nxt = divisor;
    end else if (run_r) begin
      // subtract when the shifted partial remainder covers the divisor
      rem_nxt = diff[PERIOD_W+1] ? shifted[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
      dvd_nxt = {dvd_r[PERIOD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PERIOD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

// ----- design/ptd_slot_table.sv -----
// ----------------------------------------------------------------------------
// ptd_slot_table
// Period memory, occupied and resumed marks, and the creation cursor.
// ----------------------------------------------------------------------------
module ptd_slot_table #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ptd_pkg::ptd_tbl_cmd_t        cmd,
  input  logic [ptd_pkg::PERIOD_W-1:0] cmd_period,
  input  logic [ptd_pkg::TASK_W-1:0]   rd_addr,
  output logic [ptd_pkg::PERIOD_W-1:0] rd_period,
  output logic                         rd_live
);
  import ptd_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CUR_W = $clog2(SLOT_COUNT + 1);
  localparam int WIDE_W = IDX_W + TASK_W;

  logic [PERIOD_W-1:0]   period_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] occ_r, occ_nxt;
  logic [SLOT_COUNT-1:0] res_r, res_nxt;
  logic [CUR_W-1:0]      cursor_r, cursor_nxt;
  logic [WIDE_W-1:0]     cmd_wide, rd_wide;
  logic [IDX_W-1:0]      cmd_slot, rd_slot, cur_slot;
  logic                  cmd_in_range;
  logic                  cur_in_range;
  logic                  do_write;
  logic [PERIOD_W-1:0]   rd_period_r;
  logic                  rd_live_r;

  assign cmd_wide     = WIDE_W'(cmd.idx);
  assign rd_wide      = WIDE_W'(rd_addr);
  assign cmd_slot     = cmd_wide[IDX_W-1:0];
  assign rd_slot      = rd_wide[IDX_W-1:0];
  assign cur_slot     = cursor_r[IDX_W-1:0];
  assign cmd_in_range = (32'(cmd.idx) < SLOT_COUNT);
  assign cur_in_range = (32'(cursor_r) < SLOT_COUNT);
  assign do_write     = cmd.create && cur_in_range && !occ_r[cur_slot];

  always_comb begin
    occ_nxt    = occ_r;
    res_nxt    = res_r;
    cursor_nxt = cursor_r;
    if (cmd.create && cur_in_range) begin
      cursor_nxt = cursor_r + 1'b1;
      if (!occ_r[cur_slot]) begin
        occ_nxt[cur_slot] = 1'b1;
        res_nxt[cur_slot] = 1'b1;
      end
    end
    if (cmd_in_range) begin
      if (cmd.resume)  res_nxt[cmd_slot] = 1'b1;
      if (cmd.suspend) res_nxt[cmd_slot] = 1'b0;
      if (cmd.remove)  occ_nxt[cmd_slot] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      res_r    <= '0;
      cursor_r <= '0;
    end else begin
      occ_r    <= occ_nxt;
      res_r    <= res_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // period is only used for occupied slots, which always were written first
  always_ff @(posedge clk) begin
    if (do_write) begin
      period_mem[cur_slot] <= cmd_period;
    end
    rd_period_r <= period_mem[rd_slot];
    rd_live_r   <= occ_r[rd_slot] && res_r[rd_slot];
  end

  assign rd_period = rd_period_r;
  assign rd_live   = rd_live_r;

endmodule

// ----- design/periodic_task_dispatcher.sv -----
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Time-triggered periodic task scheduler with a shared remainder unit.
// ----------------------------------------------------------------------------
// Create, resume, suspend and delete commands take effect in the cycle they
// are accepted and leave busy low. A tick command raises busy while slots
// 0..min(SLOT_COUNT,8)-1 are scanned one at a time: a slot that is empty,
// suspended or has a zero period passes through READ, CHECK and ADVANCE, and
// a live slot through READ, CHECK, DIVIDE and ADVANCE, running the single
// bit-serial remainder unit (32 steps) on the new tick count. Due slots come
// out in slot order, one per out_valid pulse, with out_last on the final one;
// the receiver cannot stall, and results are never closer than one per
// remainder pass except the last, which may follow the one before it.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ptd_pkg::KIND_W-1:0]   in_kind,
  input  logic [ptd_pkg::TASK_W-1:0]   in_task_index,
  input  logic [ptd_pkg::PERIOD_W-1:0] in_period,
  output logic                         out_valid,
  output logic [ptd_pkg::TASK_W-1:0]   out_due_task,
  output logic                         out_last
);
  import ptd_pkg::*;

  localparam int SCAN_LAST = ((SLOT_COUNT > SCAN_MAX) ? SCAN_MAX : SLOT_COUNT) - 1;

  ptd_state_t          state_r, state_nxt;
  logic [TASK_W-1:0]   scan_r, scan_nxt;
  logic [TASK_W-1:0]   pend_r, pend_nxt;
  logic                have_pend_r, have_pend_nxt;
  logic [PERIOD_W-1:0] count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TASK_W-1:0]   out_task_r, out_task_nxt;
  logic                out_last_r, out_last_nxt;

  logic                accept;
  ptd_tbl_cmd_t        tbl_cmd;
  logic [PERIOD_W-1:0] rd_period;
  logic                rd_live;
  logic                rem_start;
  ptd_rem_stat_t       rem_stat;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    tbl_cmd     = '0;
    tbl_cmd.idx = in_task_index;
    if (accept) begin
      unique case (in_kind)
        KIND_TICK:    ;
        KIND_CREATE:  tbl_cmd.create  = 1'b1;
        KIND_RESUME:  tbl_cmd.resume  = 1'b1;
        KIND_SUSPEND: tbl_cmd.suspend = 1'b1;
        KIND_DELETE:  tbl_cmd.remove  = 1'b1;
        default:      ;
      endcase
    end
  end

  ptd_slot_table #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (tbl_cmd),
    .cmd_period (in_period),
    .rd_addr    (scan_r),
    .rd_period  (rd_period),
    .rd_live    (rd_live)
  );

  assign rem_start = (state_r == ST_CHECK) && rd_live && (rd_period != '0);

  ptd_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (count_r),
    .divisor  (rd_period),
    .stat     (rem_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_task_nxt  = out_task_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_TICK)) begin
          count_nxt     = count_r + 1'b1;
          scan_nxt      = '0;
          have_pend_nxt = 1'b0;
          state_nxt     = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = rem_start ? ST_DIVIDE : ST_ADVANCE;
      end
      ST_DIVIDE: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            // hold this hit until we know whether another follows
            if (have_pend_r) begin
              out_valid_nxt = 1'b1;
              out_task_nxt  = pend_r;
              out_last_nxt  = 1'b0;
            end
            pend_nxt      = scan_r;
            have_pend_nxt = 1'b1;
          end
          state_nxt = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        if (scan_r == TASK_W'(SCAN_LAST)) begin
          if (have_pend_r) begin
            out_valid_nxt = 1'b1;
            out_task_nxt  = pend_r;
            out_last_nxt  = 1'b1;
          end
          have_pend_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_pend_r <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_pend_r <= have_pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    pend_r     <= pend_nxt;
    out_task_r <= out_task_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_due_task = out_task_r;
  assign out_last     = out_last_r;

  a_idle_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !busy) |-> out_last)
    else $error("result after scan end without last mark");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_valid)
    else $error("result follows a command transfer");

  a_rem_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.done |-> (state_r == ST_DIVIDE))
    else $error("remainder finished outside divide step");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_DIVIDE || $past(state_r) == ST_ADVANCE))
    else $error("result raised from unexpected state");

endmodule
